/* rtl/core/mcpg_pkg.sv */
// Shared constants, codes and types of the midpoint circle point generator.
package mcpg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int RAD_BITS     = COORD_BITS - 1;
  localparam int PT_BITS      = COORD_BITS + 1;
  localparam int DEC_BITS     = COORD_BITS + 2;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam int GROUP_POINTS = 8;
  localparam int IDX_BITS     = $clog2(GROUP_POINTS);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef logic [IDX_BITS-1:0] idx_t;

  localparam idx_t IDX_LAST = idx_t'(GROUP_POINTS - 1);

  // One step's worth of work for the point emitter.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic        [COORD_BITS-1:0] ox;
    logic        [COORD_BITS-1:0] oy;
    logic                         done;
  } group_t;

endpackage

/* rtl/core/mcpg_cmd_if.sv */
// Command channel: opcode, center and radius words.
interface mcpg_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic signed [mcpg_pkg::COORD_BITS-1:0] center_x;
  logic signed [mcpg_pkg::COORD_BITS-1:0] center_y;
  logic        [mcpg_pkg::RAD_BITS-1:0]   radius;

  modport source (output valid, opcode, center_x, center_y, radius, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, output ready);
endinterface

/* rtl/core/mcpg_point_if.sv */
// Point channel: one plotted pixel per word.
interface mcpg_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcpg_pkg::PT_BITS-1:0] point_x;
  logic signed [mcpg_pkg::PT_BITS-1:0] point_y;
  logic                                last_of_group;
  logic                                circle_done;

  modport source (output valid, point_x, point_y, last_of_group, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, last_of_group, circle_done, output ready);
endinterface

/* rtl/core/midpoint_circle_point_generator.sv */
// Top level of the midpoint circle point generator.
//
// Usage:
//   cmd   : one word per command. opcode start loads center_x/center_y/radius
//           and emits the first eight points; opcode advance runs one midpoint
//           step and emits eight more. An advance with no circle running is
//           swallowed and emits nothing.
//   point : eight words per step, in octant order, last_of_group on the
//           eighth, circle_done on all eight of the group that ends the circle.
// A group goes through the queue, the group register and the output register.
// Throughput: the point channel moves one word per cycle while point.ready is high
//   and a group is waiting; queued groups follow each other with no gap.
// The front end updates circle state in the cycle a command is taken and
//   parks the group in a 2-deep queue; cmd.ready drops only when that queue
//   is full, so up to two commands (plus the one being emitted) are buffered.
// When point.ready is low the output register holds its word and the emitter
//   stops; the front end keeps taking commands until the queue fills.
// Reset (rst, synchronous): circle goes idle, queue and output empty.
module midpoint_circle_point_generator (
  input  logic         clk,
  input  logic         rst,
  mcpg_cmd_if.sink     cmd,
  mcpg_point_if.source point
);

  mcpg_pkg::group_t push_data, pop_data;
  logic             push, full, pop, avail;

  // state + midpoint step
  mcpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .grp_data (push_data),
    .grp_push (push),
    .grp_full (full)
  );

  // decouples command side from point side
  mcpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  // eight-way mirror, one point per cycle while a group is in hand and point.ready is high
  mcpg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (avail),
    .q_data  (pop_data),
    .q_pop   (pop),
    .point   (point)
  );

endmodule

/* rtl/core/mcpg_front.sv */
// Command front end: holds circle state, runs the midpoint step, queues groups.
module mcpg_front (
  input  logic                clk,
  input  logic                rst,
  mcpg_cmd_if.sink            cmd,
  output mcpg_pkg::group_t    grp_data,
  output logic                grp_push,
  input  logic                grp_full
);

  logic        [mcpg_pkg::COORD_BITS-1:0] offset_x, offset_x_next;
  logic        [mcpg_pkg::COORD_BITS-1:0] offset_y, offset_y_next;
  logic        [mcpg_pkg::DEC_BITS-1:0]   decision, decision_next;
  logic signed [mcpg_pkg::COORD_BITS-1:0] held_cx, held_cx_next;
  logic signed [mcpg_pkg::COORD_BITS-1:0] held_cy, held_cy_next;
  logic                                   active, active_next;

  logic accept;
  logic is_start;
  logic done_next;

  assign cmd.ready = !grp_full;
  assign accept    = cmd.valid && cmd.ready;
  assign is_start  = (mcpg_pkg::opcode_t'(cmd.opcode) == mcpg_pkg::OP_START);

  always_comb begin
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    held_cx_next  = held_cx;
    held_cy_next  = held_cy;
    if (accept && is_start) begin
      held_cx_next  = cmd.center_x;
      held_cy_next  = cmd.center_y;
      offset_x_next = '0;
      offset_y_next = mcpg_pkg::COORD_BITS'(cmd.radius);
      decision_next = mcpg_pkg::DEC_BITS'(1) - mcpg_pkg::DEC_BITS'(cmd.radius);
    end else if (accept && active) begin
      if (decision[mcpg_pkg::DEC_BITS-1]) begin
        decision_next = decision + mcpg_pkg::DEC_BITS'({offset_x, 1'b0})
                        + mcpg_pkg::DEC_BITS'(3);
      end else begin
        decision_next = decision + mcpg_pkg::DEC_BITS'({offset_x, 1'b0})
                        - mcpg_pkg::DEC_BITS'({offset_y, 1'b0})
                        + mcpg_pkg::DEC_BITS'(5);
        offset_y_next = offset_y - mcpg_pkg::COORD_BITS'(1);
      end
      offset_x_next = offset_x + mcpg_pkg::COORD_BITS'(1);
    end
  end

  assign done_next = !(offset_x_next < offset_y_next);
  assign grp_push  = accept && (is_start || active);

  always_comb begin
    active_next = active;
    if (grp_push) begin
      active_next = !done_next;
    end
  end

  assign grp_data = '{cx: held_cx_next, cy: held_cy_next, ox: offset_x_next,
                      oy: offset_y_next, done: done_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      decision <= '0;
      held_cx  <= '0;
      held_cy  <= '0;
      active   <= 1'b0;
    end else begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
      held_cx  <= held_cx_next;
      held_cy  <= held_cy_next;
      active   <= active_next;
    end
  end

endmodule

/* rtl/core/mcpg_queue.sv */
// Short group queue between front end and point emitter.
module mcpg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mcpg_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output mcpg_pkg::group_t pop_data
);

  mcpg_pkg::group_t                 entry [mcpg_pkg::QUEUE_DEPTH];
  logic [mcpg_pkg::QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [mcpg_pkg::QCNT_BITS-1:0]   count;
  logic                             do_push, do_pop;

  assign full     = (count == mcpg_pkg::QCNT_BITS'(mcpg_pkg::QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = entry[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mcpg_pkg::QPTR_BITS'(mcpg_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + mcpg_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mcpg_pkg::QPTR_BITS'(mcpg_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + mcpg_pkg::QPTR_BITS'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + mcpg_pkg::QCNT_BITS'(1);
        2'b01:   count <= count - mcpg_pkg::QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/mcpg_back.sv */
// Point emitter: walks the eight octant points of a group into an output register.
module mcpg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_avail,
  input  mcpg_pkg::group_t q_data,
  output logic             q_pop,
  mcpg_point_if.source     point
);

  mcpg_pkg::group_t               grp;
  mcpg_pkg::idx_t                 idx;
  logic                           busy;
  logic                           out_valid;
  logic [mcpg_pkg::PT_BITS-1:0]   out_x, out_y;
  logic                           out_last, out_done;

  logic                           load_en;
  logic                           swap, neg_x, neg_y;
  logic [mcpg_pkg::COORD_BITS-1:0] mag_x, mag_y;
  logic [mcpg_pkg::PT_BITS-1:0]   cx_ext, cy_ext, mx_ext, my_ext;
  logic [mcpg_pkg::PT_BITS-1:0]   px, py;

  assign load_en = busy && (!out_valid || point.ready);
  assign q_pop   = q_avail && (!busy || (load_en && idx == mcpg_pkg::IDX_LAST));

  // octant order: (x,y) (y,x) (y,-x) (x,-y) (-x,-y) (-y,-x) (-y,x) (-x,y)
  always_comb begin
    unique case (idx)
      3'd0:    {swap, neg_x, neg_y} = 3'b000;
      3'd1:    {swap, neg_x, neg_y} = 3'b100;
      3'd2:    {swap, neg_x, neg_y} = 3'b101;
      3'd3:    {swap, neg_x, neg_y} = 3'b001;
      3'd4:    {swap, neg_x, neg_y} = 3'b011;
      3'd5:    {swap, neg_x, neg_y} = 3'b111;
      3'd6:    {swap, neg_x, neg_y} = 3'b110;
      default: {swap, neg_x, neg_y} = 3'b010;
    endcase
  end

  assign mag_x  = swap ? grp.oy : grp.ox;
  assign mag_y  = swap ? grp.ox : grp.oy;
  assign cx_ext = mcpg_pkg::PT_BITS'(grp.cx);
  assign cy_ext = mcpg_pkg::PT_BITS'(grp.cy);
  assign mx_ext = mcpg_pkg::PT_BITS'(mag_x);
  assign my_ext = mcpg_pkg::PT_BITS'(mag_y);
  assign px     = neg_x ? cx_ext - mx_ext : cx_ext + mx_ext;
  assign py     = neg_y ? cy_ext - my_ext : cy_ext + my_ext;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp <= q_data;
    end
    if (load_en) begin
      out_x    <= px;
      out_y    <= py;
      out_last <= (idx == mcpg_pkg::IDX_LAST);
      out_done <= grp.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load_en) begin
        idx <= idx + mcpg_pkg::idx_t'(1);
        if (idx == mcpg_pkg::IDX_LAST) begin
          busy <= 1'b0;
        end
      end
      if (load_en) begin
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign point.valid         = out_valid;
  assign point.point_x       = out_x;
  assign point.point_y       = out_y;
  assign point.last_of_group = out_last;
  assign point.circle_done   = out_done;

endmodule

/* rtl/core/mcpg_checker.sv */
// Port-level checks for the midpoint circle point generator, bound to the top.
module mcpg_checker (
  input logic          clk,
  input logic          rst,
  mcpg_cmd_if.sink     cmd,
  mcpg_point_if.source point
);

  a_reset_out_empty: assert property (@(posedge clk) rst |=> !point.valid)
    else $error("point word valid right after reset");

  a_reset_cmd_ready: assert property (@(posedge clk) rst |=> cmd.ready)
    else $error("command channel not ready right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    point.valid && !point.ready |=> point.valid && $stable(point.point_x)
      && $stable(point.point_y) && $stable(point.last_of_group)
      && $stable(point.circle_done))
    else $error("stalled point word changed");

  a_done_group: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready && point.circle_done && !point.last_of_group
      |=> !point.valid || point.circle_done)
    else $error("circle_done dropped inside a group");

endmodule

bind midpoint_circle_point_generator mcpg_checker u_mcpg_checker (
  .clk   (clk),
  .rst   (rst),
  .cmd   (cmd),
  .point (point)
);

/* bench/tb_midpoint_circle_point_generator.sv */
// Self-checking testbench for the midpoint circle point generator.
`timescale 1ns / 1ps

module tb_midpoint_circle_point_generator;

  // Hard stop for the whole run, in clock cycles. Even with point words stalled
  // and every command gapped, the run stays well inside this limit.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 410;
  localparam int TAIL_CYCLES = 16;

  typedef logic signed [mcpg_pkg::COORD_BITS-1:0] coord_t;
  typedef logic        [mcpg_pkg::RAD_BITS-1:0]   rad_t;

  // One expected pixel on the point channel.
  typedef struct packed {
    logic [mcpg_pkg::PT_BITS-1:0] x;
    logic [mcpg_pkg::PT_BITS-1:0] y;
    logic                         last;
    logic                         done;
  } pixel_t;

  // Tracks the circle rasterizer state, predicts the pixels of every
  // accepted command and checks them in order as they arrive.
  class circle_scoreboard;
    logic        [mcpg_pkg::COORD_BITS-1:0] off_x;
    logic        [mcpg_pkg::COORD_BITS-1:0] off_y;
    logic signed [mcpg_pkg::DEC_BITS-1:0]   dec;
    coord_t                                 ctr_x;
    coord_t                                 ctr_y;
    bit                                     running;
    pixel_t                                 pixels[$];
    int                                     errors;

    function new();
      off_x   = '0;
      off_y   = '0;
      dec     = '0;
      ctr_x   = '0;
      ctr_y   = '0;
      running = 1'b0;
      errors  = 0;
    endfunction

    function void push_pixel(int px, int py, bit last, bit fin);
      pixel_t p;
      p.x    = mcpg_pkg::PT_BITS'(px);
      p.y    = mcpg_pkg::PT_BITS'(py);
      p.last = last;
      p.done = fin;
      pixels.push_back(p);
    endfunction

    // Accepted command word; returns the number of pixels it yields.
    function int note(mcpg_pkg::opcode_t op, coord_t cx, coord_t cy, rad_t r);
      int sum;
      int x;
      int y;
      int px;
      int py;
      bit fin;
      if (op == mcpg_pkg::OP_START) begin
        ctr_x = cx;
        ctr_y = cy;
        off_x = '0;
        off_y = mcpg_pkg::COORD_BITS'(r);
        dec   = mcpg_pkg::DEC_BITS'(1 - int'(r));
      end else begin
        if (!running) return 0;
        if (dec < 0) begin
          sum = int'(dec) + 2 * int'(off_x) + 3;
        end else begin
          sum   = int'(dec) + 2 * (int'(off_x) - int'(off_y)) + 5;
          off_y = off_y - 1'b1;
        end
        dec   = mcpg_pkg::DEC_BITS'(sum);
        off_x = off_x + 1'b1;
      end
      fin     = !(off_x < off_y);
      running = !fin;
      x  = int'(off_x);
      y  = int'(off_y);
      px = int'(ctr_x);
      py = int'(ctr_y);
      // octant order
      push_pixel(px + x, py + y, 1'b0, fin);
      push_pixel(px + y, py + x, 1'b0, fin);
      push_pixel(px + y, py - x, 1'b0, fin);
      push_pixel(px + x, py - y, 1'b0, fin);
      push_pixel(px - x, py - y, 1'b0, fin);
      push_pixel(px - y, py - x, 1'b0, fin);
      push_pixel(px - y, py + x, 1'b0, fin);
      push_pixel(px - x, py + y, 1'b1, fin);
      return mcpg_pkg::GROUP_POINTS;
    endfunction

    function int outstanding();
      return pixels.size();
    endfunction

    function void check(logic [mcpg_pkg::PT_BITS-1:0] gx, logic [mcpg_pkg::PT_BITS-1:0] gy,
                        logic glast, logic gdone);
      pixel_t e;
      if (pixels.size() == 0) begin
        $error("point word with nothing expected: x %0d y %0d",
               $signed(gx), $signed(gy));
        errors++;
        return;
      end
      e = pixels.pop_front();
      if (gx !== e.x) begin
        $error("point_x: expected %0d, got %0d", $signed(e.x), $signed(gx));
        errors++;
      end
      if (gy !== e.y) begin
        $error("point_y: expected %0d, got %0d", $signed(e.y), $signed(gy));
        errors++;
      end
      if (glast !== e.last) begin
        $error("last_of_group: expected %0b, got %0b", e.last, glast);
        errors++;
      end
      if (gdone !== e.done) begin
        $error("circle_done: expected %0b, got %0b", e.done, gdone);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  // When set, neither side idles: a long burst at full rate.
  bit   steady;
  int   cycle_count;

  mcpg_cmd_if   cmd_ch();
  mcpg_point_if pt_ch();

  midpoint_circle_point_generator DUT (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .point (pt_ch)
  );

  circle_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Point sink: check every accepted word, then pick next cycle's ready.
  // Ready is low about 16 percent of the time unless a steady burst runs.
  always @(posedge clk) begin
    if (rst) begin
      pt_ch.ready <= 1'b0;
    end else begin
      if (pt_ch.valid && pt_ch.ready)
        sb.check(pt_ch.point_x, pt_ch.point_y, pt_ch.last_of_group, pt_ch.circle_done);
      pt_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drive one command word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Returns the number of pixels it should yield,
  // which is zero for an advance with no circle running.
  task automatic send_word(input mcpg_pkg::opcode_t op, input coord_t cx,
                           input coord_t cy, input rad_t r, output int produced);
    while (!steady && $urandom_range(0, 99) < 16) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.center_x <= cx;
    cmd_ch.center_y <= cy;
    cmd_ch.radius   <= r;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    produced = sb.note(op, cx, cy, r);
  endtask

  // Hold off the command side until every expected point has come back.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  int   words_done;
  int   n;
  int   steps;
  int   cap;
  int   kind;
  bit   drained_mid;
  rad_t rad;

  initial begin
    rst             = 1'b1;
    steady          = 1'b0;
    drained_mid     = 1'b0;
    words_done      = 0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.opcode   = mcpg_pkg::OP_START;
    cmd_ch.center_x = '0;
    cmd_ch.center_y = '0;
    cmd_ch.radius   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed words ---
    // advance right after reset: swallowed, no points
    send_word(mcpg_pkg::OP_ADVANCE, 12'sd0, 12'sd0, '0, n);
    // zero radius: eight copies of the center, circle ends at once
    send_word(mcpg_pkg::OP_START, 12'sd0, 12'sd0, '0, n);
    // advance after a finished circle: swallowed
    send_word(mcpg_pkg::OP_ADVANCE, 12'sd5, -12'sd5, 11'd7, n);
    // most negative center with the largest radius
    send_word(mcpg_pkg::OP_START, -12'sd2048, -12'sd2048, 11'd2047, n);
    repeat (3) send_word(mcpg_pkg::OP_ADVANCE, '0, '0, '0, n);
    // new start while a circle is running abandons the old one
    send_word(mcpg_pkg::OP_START, 12'sd2047, 12'sd2047, 11'd2047, n);
    repeat (3) send_word(mcpg_pkg::OP_ADVANCE, 12'sd2047, 12'sd2047, 11'd2047, n);
    // radius one: finishes on the first advance, through the d >= 0 branch
    send_word(mcpg_pkg::OP_START, 12'sd2047, -12'sd2048, 11'd1, n);
    send_word(mcpg_pkg::OP_ADVANCE, '0, '0, '0, n);
    // small complete circle, both decision branches
    send_word(mcpg_pkg::OP_START, -12'sd2048, 12'sd2047, 11'd5, n);
    while (sb.running) send_word(mcpg_pkg::OP_ADVANCE, '0, '0, '0, n);
    send_word(mcpg_pkg::OP_ADVANCE, '0, '0, '0, n);

    // let the block run dry once before the random part
    drain();

    // --- random words ---
    // Mostly whole circles with small radii; some large ones cut off after
    // 40 steps, some broken sequences and stray advances.
    while (words_done < RANDOM_WORDS) begin
      steady = (words_done >= 200 && words_done < 280);
      if (!drained_mid && words_done >= 320) begin
        drained_mid = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        rad = ($urandom_range(0, 9) == 0) ? rad_t'($urandom) : rad_t'($urandom_range(0, 24));
        send_word(mcpg_pkg::OP_START, coord_t'($urandom), coord_t'($urandom), rad, n);
        words_done += (n != 0);
        cap = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 6) : 40;
        steps = 0;
        while (sb.running && steps < cap) begin
          send_word(mcpg_pkg::OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                    rad_t'($urandom), n);
          words_done += (n != 0);
          steps++;
        end
      end else if (kind < 90) begin
        // stray advance: swallowed unless a circle is still open
        send_word(mcpg_pkg::OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  rad_t'($urandom), n);
        words_done += (n != 0);
      end else begin
        send_word(mcpg_pkg::OP_START, coord_t'($urandom), coord_t'($urandom),
                  rad_t'($urandom), n);
        words_done += (n != 0);
        repeat ($urandom_range(1, 3)) begin
          send_word(mcpg_pkg::OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                    rad_t'($urandom), n);
          words_done += (n != 0);
        end
      end
    end
    steady = 1'b0;

    // wait out the remaining points, then idle for strays
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
